// File: hdl/rrbm_pkg.sv
// rrbm_pkg: shared types and constants for the rom/ram bank mapper
// used by rom_ram_bank_mapper and rom_ram_bank_mapper_tb
`default_nettype none

package rrbm_pkg;

    localparam int ROM_BANK_BYTES = 16384;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int RAM_BANKS      = 4;
    localparam int STORE_DEPTH    = RAM_BANKS * RAM_BANK_BYTES;
    localparam int STORE_AW       = $clog2(STORE_DEPTH);
    localparam int ROM_OFS_W      = $clog2(ROM_BANK_BYTES);
    localparam int RAM_OFS_W      = $clog2(RAM_BANK_BYTES);
    localparam int ADDR_W         = 16;
    localparam int DATA_W         = 8;
    localparam int ROM_ADDR_W     = 21;
    localparam int LOW_BANK_W     = 5;
    localparam int HIGH_BANK_W    = 2;

    // bus access kind
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register-select field, address bits 14:13 inside the rom window
    localparam logic [1:0] REG_RAM_EN   = 2'd0;
    localparam logic [1:0] REG_LOW_BANK = 2'd1;
    localparam logic [1:0] REG_HI_BANK  = 2'd2;
    localparam logic [1:0] REG_MODE     = 2'd3;

    localparam logic [DATA_W-1:0] RAM_EN_KEY = 8'h0A;
    localparam logic [DATA_W-1:0] LOW_MASK   = 8'h1F;

    typedef enum logic [1:0] {
        KIND_ROM   = 2'd0,
        KIND_RAM   = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_OOR   = 2'd3
    } t_kind;

    // item between the issue stage and the output register
    typedef struct packed {
        t_kind                  kind;
        logic [ROM_ADDR_W-1:0]  rom_address;
        logic                   ram_rd;
    } t_s1;

endpackage

`default_nettype wire

// File: hdl/rrbm_ram.sv
// rrbm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module rrbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/rom_ram_bank_mapper.sv
// rom_ram_bank_mapper: top level of the cartridge bank controller
// depends on rrbm_pkg and rrbm_ram
//
// usage
//   input channel: i_valid / o_stall with i_op, i_address, i_write_data, one bus
//   access per beat. output channel: o_valid / i_stall with o_kind,
//   o_rom_address and o_read_data, exactly one result beat per input beat, in order.
//   path: a beat is taken into the issue stage, where its cartridge ram read is
//   in flight, then moves to the output register that drives the result.
//   throughput: one beat per cycle while i_stall is low, set by the single write
//   and read port of the cartridge ram; register writes take effect for the very next beat.
//   stall: while i_stall holds a result, one more beat is taken into the issue
//   stage, then o_stall rises until the output register drains.
//   reset: ram enabled, low bank 1, high bank 0, rom banking mode, pipeline
//   empty. the cartridge ram is not cleared; reading a never-written byte
//   returns whatever the ram holds.
`default_nettype none

module rom_ram_bank_mapper
    import rrbm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input beats
    input  wire logic                   i_valid,
    output      logic                   o_stall,
    input  wire logic                   i_op,
    input  wire logic [ADDR_W-1:0]      i_address,
    input  wire logic [DATA_W-1:0]      i_write_data,
    // result beats
    output      logic                   o_valid,
    input  wire logic                   i_stall,
    output      logic [1:0]             o_kind,
    output      logic [ROM_ADDR_W-1:0]  o_rom_address,
    output      logic [DATA_W-1:0]      o_read_data
);

    // control registers
    logic                   r_ram_on;
    logic [LOW_BANK_W-1:0]  r_low_bank;
    logic [HIGH_BANK_W-1:0] r_high_bank;
    logic                   r_bank_mode;

    // issue stage (ram read in flight) and output register
    logic                   r_s1_valid;
    t_s1                    r_s1;
    logic                   r_out_valid;
    t_kind                  r_out_kind;
    logic [ROM_ADDR_W-1:0]  r_out_rom;
    logic [DATA_W-1:0]      r_out_data;

    logic                   out_free;
    logic                   s1_move;
    logic                   accept;
    t_s1                    n_s1;

    logic                   in_rom_win;
    logic                   in_ram_win;
    logic                   is_write;
    logic [1:0]             reg_sel;
    logic [LOW_BANK_W-1:0]  low_masked;
    logic [ROM_ADDR_W-ROM_OFS_W-1:0] rom_bank;
    logic [HIGH_BANK_W-1:0] ram_bank;
    logic [STORE_AW-1:0]    store_idx;
    logic                   ram_we;
    logic                   ram_re;
    logic [DATA_W-1:0]      ram_rdata;

    // handshake: output register frees when empty or taken; issue stage moves
    // whenever the output register can take it
    assign out_free = !r_out_valid || !i_stall;
    assign s1_move  = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign accept   = i_valid && !o_stall;

    // address decode
    assign is_write   = (i_op == OP_WRITE);
    assign in_rom_win = !i_address[ADDR_W-1];
    assign in_ram_win = (i_address[ADDR_W-1:RAM_OFS_W] == 3'b101);
    assign reg_sel    = i_address[ADDR_W-2:RAM_OFS_W];
    assign low_masked = i_write_data[LOW_BANK_W-1:0] & LOW_MASK[LOW_BANK_W-1:0];

    // upper rom window: low bank, with high bank on top in rom banking mode
    assign rom_bank = r_bank_mode ? {{HIGH_BANK_W{1'b0}}, r_low_bank}
                                  : {r_high_bank, r_low_bank};

    // ram bank only follows the high bank in ram banking mode
    assign ram_bank  = r_bank_mode ? r_high_bank : '0;
    assign store_idx = {ram_bank, i_address[RAM_OFS_W-1:0]};

    // writes commit at the accept edge, so a read accepted in the next cycle
    // already sees the new byte; one beat per cycle means no same-edge clash
    assign ram_we = accept && in_ram_win && is_write && r_ram_on;
    assign ram_re = accept && in_ram_win && !is_write && r_ram_on;

    always_comb begin
        n_s1 = '{kind: KIND_OOR, rom_address: '0, ram_rd: 1'b0};
        if (in_rom_win) begin
            if (is_write) begin
                n_s1.kind = KIND_WRITE;
            end else begin
                n_s1.kind = KIND_ROM;
                if (!i_address[ROM_OFS_W]) begin
                    // fixed bank 0
                    n_s1.rom_address = ROM_ADDR_W'(i_address[ROM_OFS_W-1:0]);
                end else begin
                    n_s1.rom_address = {rom_bank, i_address[ROM_OFS_W-1:0]};
                end
            end
        end else if (in_ram_win) begin
            n_s1.kind   = is_write ? KIND_WRITE : KIND_RAM;
            n_s1.ram_rd = !is_write && r_ram_on;
        end
    end

    // control register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_on    <= 1'b1;
            r_low_bank  <= LOW_BANK_W'(1);
            r_high_bank <= '0;
            r_bank_mode <= 1'b0;
        end else if (accept && in_rom_win && is_write) begin
            case (reg_sel)
                REG_RAM_EN: begin
                    r_ram_on <= ((i_write_data & RAM_EN_KEY) == RAM_EN_KEY);
                end
                REG_LOW_BANK: begin
                    // zero test on the masked value
                    r_low_bank <= (low_masked == '0) ? LOW_BANK_W'(1) : low_masked;
                end
                REG_HI_BANK: begin
                    r_high_bank <= i_write_data[HIGH_BANK_W-1:0];
                end
                REG_MODE: begin
                    r_bank_mode <= i_write_data[0];
                end
                default: begin
                    r_bank_mode <= r_bank_mode;
                end
            endcase
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_out_kind <= r_s1.kind;
            r_out_rom  <= r_s1.rom_address;
            // disabled ram and non-ram results read as zero
            r_out_data <= r_s1.ram_rd ? ram_rdata : '0;
        end
    end

    rrbm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (store_idx),
        .i_wdata (i_write_data),
        .i_re    (ram_re),
        .i_raddr (store_idx),
        .o_rdata (ram_rdata)
    );

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_rom_address = r_out_rom;
    assign o_read_data   = r_out_data;

endmodule

`default_nettype wire

// File: bench/rom_ram_bank_mapper_tb.sv
// rom_ram_bank_mapper_tb: self-checking bench for the cartridge bank controller
// depends on rrbm_pkg and rom_ram_bank_mapper; directed accesses, then random
// bus traffic with bursty idling on both channels against a bit-true predictor
`timescale 1ns / 1ps

module rom_ram_bank_mapper_tb;
    import rrbm_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_BEATS = 1300;
    localparam int          QUIET_FROM   = 1100;
    localparam int          DRAIN_CYCLES = 8;

    // one predicted result beat
    typedef struct packed {
        t_kind                  kind;
        logic [ROM_ADDR_W-1:0]  rom_address;
        logic [DATA_W-1:0]      read_data;
    } t_map_result;

    // predictor of the mapper plus the queue of results still owed
    class t_access_scoreboard;
        logic                    en_ram;
        logic [LOW_BANK_W-1:0]   bank_lo;
        logic [HIGH_BANK_W-1:0]  bank_hi;
        logic                    mode_ram;
        logic [DATA_W-1:0]       cart_bytes [STORE_DEPTH];
        bit                      cart_valid [STORE_DEPTH];
        t_map_result             pending [$];
        int unsigned             errors;

        function new();
            en_ram   = 1'b1;
            bank_lo  = LOW_BANK_W'(1);
            bank_hi  = '0;
            mode_ram = 1'b0;
            errors   = 0;
        endfunction

        static function bit ram_window(logic [ADDR_W-1:0] addr);
            return addr >= 16'hA000 && addr < 16'hC000;
        endfunction

        // ram bank follows the high bank only in ram banking mode
        function logic [STORE_AW-1:0] slot(logic [ADDR_W-1:0] addr);
            return {(mode_ram ? bank_hi : 2'b00), addr[RAM_OFS_W-1:0]};
        endfunction

        function bit is_filled(logic [ADDR_W-1:0] addr);
            return cart_valid[slot(addr)];
        endfunction

        function void note(logic op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
            t_map_result             r;
            logic [LOW_BANK_W-1:0]   lo;
            logic [6:0]              bank;
            r      = '0;
            r.kind = KIND_OOR;
            if (!addr[15]) begin
                if (op == OP_WRITE) begin
                    r.kind = KIND_WRITE;
                    case (addr[14:13])
                        REG_RAM_EN: begin
                            en_ram = (data & RAM_EN_KEY) == RAM_EN_KEY;
                        end
                        REG_LOW_BANK: begin
                            // zero test on the masked value
                            lo      = data[LOW_BANK_W-1:0];
                            bank_lo = (lo == '0) ? LOW_BANK_W'(1) : lo;
                        end
                        REG_HI_BANK: begin
                            bank_hi = data[HIGH_BANK_W-1:0];
                        end
                        REG_MODE: begin
                            mode_ram = data[0];
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    r.kind = KIND_ROM;
                    if (!addr[14]) begin
                        r.rom_address = ROM_ADDR_W'(addr);
                    end else begin
                        bank          = {(mode_ram ? 2'b00 : bank_hi), bank_lo};
                        r.rom_address = {bank, addr[ROM_OFS_W-1:0]};
                    end
                end
            end else if (ram_window(addr)) begin
                if (op == OP_WRITE) begin
                    r.kind = KIND_WRITE;
                    if (en_ram) begin
                        cart_bytes[slot(addr)] = data;
                        cart_valid[slot(addr)] = 1'b1;
                    end
                end else begin
                    r.kind = KIND_RAM;
                    if (en_ram) r.read_data = cart_bytes[slot(addr)];
                end
            end
            pending.push_back(r);
        endfunction

        function void check(logic [1:0] kind, logic [ROM_ADDR_W-1:0] rom,
                            logic [DATA_W-1:0] rd);
            t_map_result e;
            if (pending.size() == 0) begin
                $error("result beat with no access pending: kind %0d", kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (kind !== e.kind) begin
                $error("kind: expected %0d, actual %0d", e.kind, kind);
                errors++;
            end
            if (rom !== e.rom_address) begin
                $error("rom_address: expected %06h, actual %06h", e.rom_address, rom);
                errors++;
            end
            if (rd !== e.read_data) begin
                $error("read_data: expected %02h, actual %02h", e.read_data, rd);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic                   i_op;
    logic [ADDR_W-1:0]      i_address;
    logic [DATA_W-1:0]      i_write_data;
    logic                   o_valid;
    logic                   i_stall;
    logic [1:0]             o_kind;
    logic [ROM_ADDR_W-1:0]  o_rom_address;
    logic [DATA_W-1:0]      o_read_data;

    t_access_scoreboard sb;
    int unsigned        cycle_count;
    bit                 calm;     // a stretch with no idling on either side
    bit                 quiet;    // tail of the run, no idling at all

    rom_ram_bank_mapper i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_rom_address (o_rom_address),
        .o_read_data   (o_read_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: sampled at the rising edge, before the block updates
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check(o_kind, o_rom_address, o_read_data);
        end
    end

    // result side back-pressure, in bursts, changed on the falling edge
    initial begin : stall_gen
        int stall_left;
        stall_left = 0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && !calm && !quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11);
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // present one beat, hold it until taken, then maybe leave a gap
    task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] data);
        int gap;
        i_valid      <= 1'b1;
        i_op         <= op;
        i_address    <= addr;
        i_write_data <= data;
        do @(posedge i_clk); while (o_stall);
        sb.note(op, addr, data);
        @(negedge i_clk);
        if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
            gap     = $urandom_range(1, 11);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // random access, mostly well-formed traffic aimed at the mapped windows
    task automatic pick_access(output logic op, output logic [ADDR_W-1:0] addr,
                               output logic [DATA_W-1:0] data);
        int sel;
        int ofs;
        sel  = $urandom_range(0, 99);
        op   = 1'($urandom_range(0, 1));
        data = DATA_W'($urandom_range(0, 255));
        if (sel < 22) begin
            // control register write; bias the enable key so ram stays mostly on
            op   = OP_WRITE;
            addr = ADDR_W'($urandom_range(0, 16'h7FFF));
            if (addr[14:13] == REG_RAM_EN && $urandom_range(0, 9) < 7) data = data | RAM_EN_KEY;
        end else if (sel < 42) begin
            op   = OP_READ;
            addr = ADDR_W'($urandom_range(0, 16'h7FFF));
        end else if (sel < 82) begin
            // ram traffic, clustered at both ends of the bank so reads hit written bytes
            case ($urandom_range(0, 3))
                0:       ofs = $urandom_range(0, 31);
                1:       ofs = RAM_BANK_BYTES - 1 - $urandom_range(0, 31);
                default: ofs = $urandom_range(0, RAM_BANK_BYTES - 1);
            endcase
            addr = 16'hA000 + ADDR_W'(ofs);
        end else if (sel < 94) begin
            addr = $urandom_range(0, 1) ? ADDR_W'($urandom_range(16'h8000, 16'h9FFF))
                                        : ADDR_W'($urandom_range(16'hC000, 16'hFFFF));
        end else begin
            addr = ADDR_W'($urandom_range(0, 16'hFFFF));
        end
        // never read a ram byte that has not been written; write it instead
        if (op == OP_READ && t_access_scoreboard::ram_window(addr) && !sb.is_filled(addr)) begin
            op = OP_WRITE;
        end
    endtask

    initial begin : main
        logic               op;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;

        sb           = new();
        cycle_count  = 0;
        calm         = 1'b1;
        quiet        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_op         = OP_READ;
        i_address    = '0;
        i_write_data = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // bank 0 window and the reset bank in the upper window
        send_access(OP_READ,  16'h0000, 8'h00);
        send_access(OP_READ,  16'h3FFF, 8'hFF);
        send_access(OP_READ,  16'h4000, 8'h00);
        send_access(OP_READ,  16'h7FFF, 8'h00);
        // low bank zero, plain and through the mask, then the largest rom bank
        send_access(OP_WRITE, 16'h2000, 8'h00);
        send_access(OP_READ,  16'h4000, 8'h00);
        send_access(OP_WRITE, 16'h2000, 8'h20);
        send_access(OP_READ,  16'h4001, 8'h00);
        send_access(OP_WRITE, 16'h3FFF, 8'hFF);
        send_access(OP_WRITE, 16'h4000, 8'hFF);
        send_access(OP_READ,  16'h7FFF, 8'h00);
        // rom banking mode: ram writes and reads land in bank 0
        send_access(OP_WRITE, 16'hA000, 8'h55);
        send_access(OP_READ,  16'hA000, 8'h00);
        send_access(OP_WRITE, 16'hBFFF, 8'hAA);
        send_access(OP_READ,  16'hBFFF, 8'h00);
        // ram banking mode: high bank drops out of the rom address
        send_access(OP_WRITE, 16'h6000, 8'h01);
        send_access(OP_READ,  16'h4000, 8'h00);
        send_access(OP_WRITE, 16'hA000, 8'h33);
        // disabled ram reads zero and ignores writes
        send_access(OP_WRITE, 16'h0000, 8'h00);
        send_access(OP_READ,  16'hA000, 8'h00);
        send_access(OP_WRITE, 16'hA000, 8'h77);
        send_access(OP_WRITE, 16'h1FFF, 8'h0A);
        send_access(OP_READ,  16'hA000, 8'h00);
        // unmapped windows, both kinds of access, then mode and high bank back to reset values
        send_access(OP_READ,  16'h8000, 8'h00);
        send_access(OP_WRITE, 16'h9FFF, 8'hFF);
        send_access(OP_READ,  16'hC000, 8'h00);
        send_access(OP_WRITE, 16'hFFFF, 8'hFF);
        send_access(OP_WRITE, 16'h7FFF, 8'h00);
        send_access(OP_WRITE, 16'h5FFF, 8'h00);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
            quiet = (n >= QUIET_FROM);
            pick_access(op, addr, data);
            send_access(op, addr, data);
        end
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
